### rtl/tmhl_pkg.sv
package tmhl_pkg;

    localparam int MAX_TRIANGLES_DEF = 256;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIFT    = 2'd2;

    localparam logic [8:0]         COUNT_RESET = 9'd0;
    localparam logic signed [15:0] FLOOR_RESET = -16'sd2294;
    localparam logic signed [15:0] LIFT_RESET  = 16'sd164;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int CORNER_W = 48;
    localparam int ROW_W    = 3 * CORNER_W;
    localparam int NW       = 40;
    localparam int DW       = 64;
    localparam int QW       = 17;

    typedef struct packed {
        logic               operation;
        logic [7:0]         tri_index;
        logic [1:0]         corner;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] height;
        logic               found;
        logic [7:0]         hit_index;
    } t_out_word;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_corner;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] num;
        logic [DW-1:0] den;
    } t_div_req;

endpackage

### rtl/tmhl_div.sv
module tmhl_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tmhl_pkg::t_div_req       i_req,
    output logic                     o_done,
    output logic [tmhl_pkg::QW-1:0]  o_quo
);

    localparam int CW = $clog2(tmhl_pkg::QW + 1);

    logic [tmhl_pkg::DW-1:0] r_rem;
    logic [tmhl_pkg::DW-1:0] r_dvs;
    logic [tmhl_pkg::QW-1:0] r_quo;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic                    n_ge;

    assign n_ge = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(tmhl_pkg::QW);
                r_rem  <= i_req.num;
                r_dvs  <= i_req.den << (tmhl_pkg::QW - 1);
                r_quo  <= '0;
            end else if (r_busy) begin
                if (n_ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_quo <= {r_quo[tmhl_pkg::QW-2:0], n_ge};
                r_dvs <= r_dvs >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/triangle_mesh_height_lookup.sv
// A load word writes one triangle corner and never raises busy. A query
// scans the first N = min(triangle_count, MAX_TRIANGLES) triangles through the corner
// memory's read port, one triangle per cycle. With no match the result appears once the
// scan and its pipeline have drained. A match at index t passes through the memory read
// register and the difference and product registers to the hit test, then three
// multiply-accumulate steps, a divider start register, the divider load and 17 steps, and the output
// register. The result word is shown for exactly one cycle with o_valid and cannot be held
// off by the receiver.
module triangle_mesh_height_lookup #(
    parameter int MAX_TRIANGLES = tmhl_pkg::MAX_TRIANGLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tmhl_pkg::t_in_word              i_word,
    output logic                            o_valid,
    output tmhl_pkg::t_out_word             o_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tmhl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);

    localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
    localparam int NW    = tmhl_pkg::NW;
    localparam int DW    = tmhl_pkg::DW;
    localparam int QW    = tmhl_pkg::QW;
    localparam int MW    = NW + 18;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MAC, S_DIV} t_state;

    t_state r_state;
    logic [8:0]         r_count;
    logic signed [15:0] r_floor;
    logic signed [15:0] r_lift;

    logic [tmhl_pkg::ROW_W-1:0] r_mem [MAX_TRIANGLES];
    logic [tmhl_pkg::ROW_W-1:0] r_rd;

    logic accept;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (accept && i_word.operation == tmhl_pkg::OP_LOAD && i_word.corner != 2'd3
            && int'(i_word.tri_index) < MAX_TRIANGLES) begin
            r_mem[IDX_W'(i_word.tri_index)][i_word.corner * tmhl_pkg::CORNER_W +:
                tmhl_pkg::CORNER_W] <= {i_word.coord_x, i_word.coord_y, i_word.coord_z};
        end
    end

    logic [CNT_W-1:0]   r_issue;
    logic [CNT_W-1:0]   r_n;
    logic               n_issuing;
    logic signed [15:0] r_px;
    logic signed [15:0] r_pz;

    assign n_issuing = (r_state == S_SCAN) && (r_issue < r_n);

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_issue[IDX_W-1:0]];
    end

    logic             r_v1, r_v2, r_v3;
    logic [IDX_W-1:0] r_t1, r_t2, r_t3;

    tmhl_pkg::t_corner c1, c2, c3;
    assign c1 = r_rd[0 +: tmhl_pkg::CORNER_W];
    assign c2 = r_rd[1*tmhl_pkg::CORNER_W +: tmhl_pkg::CORNER_W];
    assign c3 = r_rd[2*tmhl_pkg::CORNER_W +: tmhl_pkg::CORNER_W];

    logic signed [16:0] r_da, r_db, r_dc, r_de, r_df, r_dg;
    logic signed [15:0] r_y2 [3];
    logic signed [15:0] r_y3 [3];
    logic               r_up2, r_up3;
    logic signed [33:0] r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;

    always_ff @(posedge i_clk) begin
        r_da <= 17'(c2.z) - 17'(c3.z);
        r_db <= 17'(c1.x) - 17'(c3.x);
        r_dc <= 17'(c3.x) - 17'(c2.x);
        r_de <= 17'(c1.z) - 17'(c3.z);
        r_df <= 17'(r_px) - 17'(c3.x);
        r_dg <= 17'(r_pz) - 17'(c3.z);
        r_y2[0] <= c1.y;
        r_y2[1] <= c2.y;
        r_y2[2] <= c3.y;
        r_up2 <= (c1.y > r_floor) && (c2.y > r_floor) && (c3.y > r_floor);
        r_p1 <= 34'(r_da) * 34'(r_db);
        r_p2 <= 34'(r_dc) * 34'(r_de);
        r_p3 <= 34'(r_da) * 34'(r_df);
        r_p4 <= 34'(r_dc) * 34'(r_dg);
        r_p5 <= 34'(r_de) * 34'(r_df);
        r_p6 <= 34'(r_db) * 34'(r_dg);
        r_y3  <= r_y2;
        r_up3 <= r_up2;
    end

    logic signed [NW-1:0] s_d, s_n1, s_n2, s_dn, s_n1n, s_n2n, s_n3;
    logic                 s_hit;

    always_comb begin
        s_d  = NW'(r_p1) + NW'(r_p2);
        s_n1 = NW'(r_p3) + NW'(r_p4);
        s_n2 = NW'(r_p6) - NW'(r_p5);
        if (s_d < 0) begin
            s_dn  = -s_d;
            s_n1n = -s_n1;
            s_n2n = -s_n2;
        end else begin
            s_dn  = s_d;
            s_n1n = s_n1;
            s_n2n = s_n2;
        end
        s_n3  = s_dn - s_n1n - s_n2n;
        s_hit = r_v3 && r_up3 && (s_d != 0) && (s_n1n >= 0) && (s_n2n >= 0) && (s_n3 >= 0);
    end

    logic signed [NW-1:0] r_w [3];
    logic signed [NW-1:0] r_den;
    logic signed [15:0]   r_yh [3];
    logic [IDX_W-1:0]     r_hit_t;
    logic [1:0]           r_k;
    logic signed [MW-1:0] r_acc;
    logic                 r_neg;
    logic signed [MW-1:0] n_prod;
    logic [DW-1:0]        n_mag;

    tmhl_pkg::t_div_req r_req;
    logic               div_done;
    logic [QW-1:0]      div_quo;

    logic signed [QW:0]   n_val;
    logic signed [QW+1:0] n_sum;
    logic signed [15:0]   n_sat;

    always_comb begin
        n_prod = MW'(r_w[r_k]) * MW'(r_yh[r_k]);
        n_mag  = (r_acc < 0) ? DW'(-r_acc) : DW'(r_acc);
        n_val  = r_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        n_sum  = (QW+2)'(n_val) + (QW+2)'(r_lift);
        if (n_sum > 32767) begin
            n_sat = 16'sd32767;
        end else if (n_sum < -32768) begin
            n_sat = -16'sd32768;
        end else begin
            n_sat = n_sum[15:0];
        end
    end

    tmhl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= tmhl_pkg::COUNT_RESET;
            r_floor   <= tmhl_pkg::FLOOR_RESET;
            r_lift    <= tmhl_pkg::LIFT_RESET;
            r_issue   <= '0;
            r_n       <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_req.start <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            o_valid     <= 1'b0;
            r_req.start <= 1'b0;
            r_v1 <= n_issuing;
            r_t1 <= r_issue[IDX_W-1:0];
            r_v2 <= r_v1;
            r_t2 <= r_t1;
            r_v3 <= r_v2;
            r_t3 <= r_t2;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tmhl_pkg::CFG_TRIANGLE_COUNT: r_count <= i_cfg_data[8:0];
                    tmhl_pkg::CFG_FLOOR_LEVEL:    r_floor <= i_cfg_data;
                    tmhl_pkg::CFG_HEIGHT_LIFT:    r_lift  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_word.operation == tmhl_pkg::OP_QUERY) begin
                        r_state <= S_SCAN;
                        r_issue <= '0;
                        r_px    <= i_word.coord_x;
                        r_pz    <= i_word.coord_z;
                        if (int'(r_count) > MAX_TRIANGLES) begin
                            r_n <= CNT_W'(MAX_TRIANGLES);
                        end else begin
                            r_n <= CNT_W'(r_count);
                        end
                    end
                end
                S_SCAN: begin
                    if (n_issuing) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (s_hit) begin
                        r_state <= S_MAC;
                        r_issue <= r_n;
                        r_v1    <= 1'b0;
                        r_v2    <= 1'b0;
                        r_v3    <= 1'b0;
                        r_w[0]  <= s_n1n;
                        r_w[1]  <= s_n2n;
                        r_w[2]  <= s_n3;
                        r_den   <= s_dn;
                        r_yh    <= r_y3;
                        r_hit_t <= r_t3;
                        r_k     <= 2'd0;
                        r_acc   <= '0;
                    end else if (!n_issuing && !r_v1 && !r_v2 && !r_v3) begin
                        r_state <= S_IDLE;
                        o_valid <= 1'b1;
                        o_word.height    <= r_floor;
                        o_word.found     <= 1'b0;
                        o_word.hit_index <= 8'd0;
                    end
                end
                S_MAC: begin
                    if (r_k == 2'd3) begin
                        r_state     <= S_DIV;
                        r_neg       <= (r_acc < 0);
                        r_req.start <= 1'b1;
                        r_req.num   <= (n_mag << 1) + DW'(r_den);
                        r_req.den   <= DW'(r_den) << 1;
                    end else begin
                        r_acc <= r_acc + n_prod;
                        r_k   <= r_k + 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_IDLE;
                        o_valid <= 1'b1;
                        o_word.height    <= n_sat;
                        o_word.found     <= 1'b1;
                        o_word.hit_index <= 8'(r_hit_t);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

endmodule

### rtl/tmhl_check.sv
module tmhl_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input tmhl_pkg::t_in_word              i_word,
    input logic                            o_valid,
    input tmhl_pkg::t_out_word             o_word
);

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe lasted two cycles");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_word.operation == tmhl_pkg::OP_QUERY) |=> busy)
        else $error("query accepted without raising busy");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_word.operation == tmhl_pkg::OP_LOAD) |=> !busy && !o_valid)
        else $error("load word caused activity");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.found) |-> (o_word.hit_index == 8'd0))
        else $error("miss result carries a triangle index");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result shown without a query in progress");

endmodule

bind triangle_mesh_height_lookup tmhl_check u_tmhl_check (.*);

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    tmhl_pkg::t_in_word  i_word = '0;
    logic            o_valid;
    tmhl_pkg::t_out_word o_word;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [tmhl_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]     i_cfg_data = '0;

    localparam int TRI_CAP = 256;
    localparam logic [tmhl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Predictor state.
    logic [8:0]         scan_count;
    logic signed [15:0] floor_lvl;
    logic signed [15:0] lift;
    logic signed [15:0] mesh_x [3*TRI_CAP];
    logic signed [15:0] mesh_y [3*TRI_CAP];
    logic signed [15:0] mesh_z [3*TRI_CAP];

    tmhl_pkg::t_in_word  pending_words [$];
    tmhl_pkg::t_out_word heights_due [$];
    int        n_accepted = 0;
    int        n_mismatch = 0;
    bit        idle_on = 1'b1;

    // Intended geometry, used to aim queries inside triangles.
    int geo_x [TRI_CAP][3];
    int geo_z [TRI_CAP][3];

    triangle_mesh_height_lookup dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .o_word      (o_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic tmhl_pkg::t_out_word lookup_height(tmhl_pkg::t_in_word w);
        tmhl_pkg::t_out_word r;
        int n;
        int b;
        longint x1, x2, x3, z1, z2, z3, px, pz, d, n1, n2, n3, num, a, q, h;
        r.height = floor_lvl;
        r.found = 1'b0;
        r.hit_index = '0;
        n = (scan_count > TRI_CAP) ? TRI_CAP : int'(scan_count);
        px = longint'(w.coord_x);
        pz = longint'(w.coord_z);
        for (int t = 0; t < n; t++) begin
            b = 3 * t;
            if (mesh_y[b] <= floor_lvl || mesh_y[b+1] <= floor_lvl || mesh_y[b+2] <= floor_lvl)
                continue;
            x1 = mesh_x[b]; x2 = mesh_x[b+1]; x3 = mesh_x[b+2];
            z1 = mesh_z[b]; z2 = mesh_z[b+1]; z3 = mesh_z[b+2];
            d  = (z2 - z3) * (x1 - x3) + (x3 - x2) * (z1 - z3);
            n1 = (z2 - z3) * (px - x3) + (x3 - x2) * (pz - z3);
            n2 = (z3 - z1) * (px - x3) + (x1 - x3) * (pz - z3);
            if (d == 0)
                continue;
            if (d < 0) begin
                d = -d; n1 = -n1; n2 = -n2;
            end
            n3 = d - n1 - n2;
            if (n1 < 0 || n2 < 0 || n3 < 0)
                continue;
            num = n1 * longint'(mesh_y[b]) + n2 * longint'(mesh_y[b+1])
                + n3 * longint'(mesh_y[b+2]);
            a = (num < 0) ? -num : num;
            q = (2 * a + d) / (2 * d);
            h = ((num < 0) ? -q : q) + longint'(lift);
            if (h > 32767) h = 32767;
            if (h < -32768) h = -32768;
            r.height = h[15:0];
            r.found = 1'b1;
            r.hit_index = t[7:0];
            break;
        end
        return r;
    endfunction

    task automatic accept_word(tmhl_pkg::t_in_word w);
        int s;
        n_accepted++;
        if (w.operation == tmhl_pkg::OP_QUERY) begin
            heights_due.insert(heights_due.size(), lookup_height(w));
        end else if (w.corner <= 2) begin
            s = 3 * w.tri_index + w.corner;
            mesh_x[s] = w.coord_x;
            mesh_y[s] = w.coord_y;
            mesh_z[s] = w.coord_z;
        end
    endtask

    always @(posedge i_clk) begin
        tmhl_pkg::t_in_word nw;
        logic ns;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_word <= '0;
        end else begin
            ns = start;
            nw = i_word;
            if (start && !busy) begin
                accept_word(i_word);
                ns = 1'b0;
            end
            idle_on = !(n_accepted >= 300 && n_accepted < 450);
            if (!ns && pending_words.size() > 0
                && !(idle_on && $urandom_range(99) < 7)) begin
                nw = pending_words.pop_front();
                ns = 1'b1;
            end
            start <= ns;
            i_word <= nw;
        end
    end

    always @(posedge i_clk) begin
        tmhl_pkg::t_out_word e;
        if (i_rst_n && o_valid) begin
            if (heights_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result word %h", o_word);
            end else begin
                e = heights_due.pop_front();
                if (o_word.height !== e.height || o_word.found !== e.found
                    || o_word.hit_index !== e.hit_index) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected h=%0d f=%0d i=%0d, got h=%0d f=%0d i=%0d",
                                 e.height, e.found, e.hit_index,
                                 o_word.height, o_word.found, o_word.hit_index);
                end
            end
        end
    end

    function automatic int clamp16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic int rand16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic push_word(logic op, int idx, int cor, int x, int y, int z);
        tmhl_pkg::t_in_word w;
        w.operation = op;
        w.tri_index = idx[7:0];
        w.corner = cor[1:0];
        w.coord_x = x[15:0];
        w.coord_y = y[15:0];
        w.coord_z = z[15:0];
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || start || heights_due.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [tmhl_pkg::CFG_IDX_W-1:0] idx, int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[15:0];
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tmhl_pkg::CFG_TRIANGLE_COUNT: scan_count = val[8:0];
            tmhl_pkg::CFG_FLOOR_LEVEL:    floor_lvl = val[15:0];
            tmhl_pkg::CFG_HEIGHT_LIFT:    lift = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Loads a random triangle with heights above the floor, or one corner at or just below the floor at times.
    task automatic load_triangle(int t, int fl, int spread);
        int cx, cz, y, low_c;
        cx = rand16();
        cz = rand16();
        low_c = ($urandom_range(9) == 0) ? int'($urandom_range(2)) : 3;
        for (int c = 0; c < 3; c++) begin
            geo_x[t][c] = clamp16(cx + int'($urandom_range(2*spread)) - spread);
            geo_z[t][c] = clamp16(cz + int'($urandom_range(2*spread)) - spread);
            if (c == low_c)
                y = fl - int'($urandom_range(1));
            else
                y = (fl >= 32767) ? rand16() : int'($urandom_range(32767 - fl - 1)) + fl + 1;
            if ($urandom_range(19) == 0 && c == 2) begin
                geo_x[t][2] = geo_x[t][0];
                geo_z[t][2] = geo_z[t][0];
            end
            push_word(tmhl_pkg::OP_LOAD, t, c, geo_x[t][c], clamp16(y), geo_z[t][c]);
        end
    endtask

    task automatic query_near(int nt);
        int t, w1, w2, w3, px, pz;
        if (nt > 0 && $urandom_range(9) < 7) begin
            t = $urandom_range(nt - 1);
            w1 = $urandom_range(64);
            w2 = $urandom_range(64 - w1);
            w3 = 64 - w1 - w2;
            px = (w1 * geo_x[t][0] + w2 * geo_x[t][1] + w3 * geo_x[t][2]) / 64;
            pz = (w1 * geo_z[t][0] + w2 * geo_z[t][1] + w3 * geo_z[t][2]) / 64;
        end else begin
            px = rand16();
            pz = rand16();
        end
        push_word(tmhl_pkg::OP_QUERY, $urandom_range(255), $urandom_range(3), px, rand16(), pz);
    endtask

    initial begin
        int nt, fl, nq, spread, n_random;
        scan_count = tmhl_pkg::COUNT_RESET;
        floor_lvl = tmhl_pkg::FLOOR_RESET;
        lift = tmhl_pkg::LIFT_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty scan, degenerate and huge triangles, saturation both ways.
        push_word(tmhl_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        push_word(tmhl_pkg::OP_LOAD, 0, 0, 0, 1000, 0);
        push_word(tmhl_pkg::OP_LOAD, 0, 1, 100, 1000, 100);
        push_word(tmhl_pkg::OP_LOAD, 0, 2, 200, 1000, 200);
        push_word(tmhl_pkg::OP_LOAD, 1, 0, -32768, 32767, -32768);
        push_word(tmhl_pkg::OP_LOAD, 1, 1, 32767, 32767, -32768);
        push_word(tmhl_pkg::OP_LOAD, 1, 2, -32768, 32767, 32767);
        push_word(tmhl_pkg::OP_LOAD, 1, 3, 5, -32768, 5);
        push_word(tmhl_pkg::OP_LOAD, 2, 0, 32767, -32767, 32767);
        push_word(tmhl_pkg::OP_LOAD, 2, 1, -32768, -32767, 32767);
        push_word(tmhl_pkg::OP_LOAD, 2, 2, 32767, -32767, -32768);
        wait_quiet();
        write_reg(tmhl_pkg::CFG_TRIANGLE_COUNT, 3);
        write_reg(tmhl_pkg::CFG_FLOOR_LEVEL, -32768);
        write_reg(tmhl_pkg::CFG_HEIGHT_LIFT, 32767);
        write_reg(CFG_UNUSED, 16'hffff);
        push_word(tmhl_pkg::OP_QUERY, 255, 3, -16000, -1, -16000);
        push_word(tmhl_pkg::OP_QUERY, 0, 0, -32768, 0, -32768);
        push_word(tmhl_pkg::OP_QUERY, 0, 0, 150, 0, 150);
        wait_quiet();
        write_reg(tmhl_pkg::CFG_HEIGHT_LIFT, -32768);
        push_word(tmhl_pkg::OP_QUERY, 0, 0, 20000, 0, 20000);
        push_word(tmhl_pkg::OP_QUERY, 0, 0, 32767, 0, 32767);
        wait_quiet();
        // A count above capacity, with a query that stops at an early triangle.
        write_reg(tmhl_pkg::CFG_TRIANGLE_COUNT, 300);
        push_word(tmhl_pkg::OP_QUERY, 0, 0, -16000, 0, -16000);
        wait_quiet();
        write_reg(tmhl_pkg::CFG_TRIANGLE_COUNT, 3);
        write_reg(tmhl_pkg::CFG_FLOOR_LEVEL, 32767);
        push_word(tmhl_pkg::OP_QUERY, 0, 0, -16000, 0, -16000);
        wait_quiet();

        // Random phases.
        n_random = 0;
        while (n_random < 580) begin
            nt = ($urandom_range(4) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 60);
            case ($urandom_range(9))
                0: fl = -32768;
                1: fl = 32767;
                2: fl = rand16();
                default: fl = -8000 - int'($urandom_range(24768));
            endcase
            spread = ($urandom_range(3) == 0) ? 32767 : $urandom_range(200, 16000);
            for (int t = 0; t < nt; t++)
                load_triangle(t, fl, spread);
            for (int k = $urandom_range(2); k > 0; k--)
                push_word(tmhl_pkg::OP_LOAD, $urandom_range(nt - 1), 3, rand16(), rand16(),
                          rand16());
            n_random += 3 * nt;
            wait_quiet();
            write_reg(tmhl_pkg::CFG_TRIANGLE_COUNT,
                      ($urandom_range(4) != 0) ? nt : $urandom_range(nt));
            write_reg(tmhl_pkg::CFG_FLOOR_LEVEL, fl);
            case ($urandom_range(5))
                0: write_reg(tmhl_pkg::CFG_HEIGHT_LIFT, 0);
                1: write_reg(tmhl_pkg::CFG_HEIGHT_LIFT, 32767);
                2: write_reg(tmhl_pkg::CFG_HEIGHT_LIFT, -32768);
                default: write_reg(tmhl_pkg::CFG_HEIGHT_LIFT, rand16());
            endcase
            nq = $urandom_range(4, 20);
            for (int k = 0; k < nq; k++)
                query_near(nt);
            n_random += nq;
            wait_quiet();
        end
        repeat (300) @(posedge i_clk);

        if (n_mismatch == 0 && heights_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule
